// ===== hdl/fcld_pkg.sv =====
// Shared types and constants for the five-channel LED driver register block.
// No dependencies; used by five_channel_led_driver_registers_unit.
package fcld_pkg;

   // Bus byte kinds
   typedef enum logic [1:0] {
      OP_ADDR   = 2'd0,
      OP_DATA   = 2'd1,
      OP_STOP   = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   // Per-byte status codes
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ADDR_ERR = 2'd1,
      ST_OVERFLOW = 2'd2,
      ST_NO_TXN   = 2'd3
   } status_type;

   // Register map layout
   localparam int          LAYOUT_CHANNELS = 5;
   localparam logic [3:0]  REG_ENABLE      = 4'h0;
   localparam logic [3:0]  CURR_BASE       = 4'h1;
   localparam logic [3:0]  GRAY_BASE       = 4'h6;
   localparam logic [4:0]  REG_COUNT       = 5'd16;
   localparam logic [4:0]  NO_REG          = 5'd16;
   localparam logic [2:0]  NO_CHANNEL      = 3'd5;

   // Address byte bit positions
   localparam int ADDR_FLAG_BIT = 7;
   localparam int AWAKE_BIT     = 5;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } req_payload_type;

   typedef struct packed {
      status_type status;
      logic       asleep;
      logic [4:0] enable_mask;
      logic [4:0] reg_written;
      logic [2:0] channel;
      logic [9:0] brightness;
      logic [7:0] current_code;
   } rsp_payload_type;

endpackage

// ===== hdl/five_channel_led_driver_registers_unit.sv =====
// Results are offered on rsp_ from the result register. One byte per cycle while
// req_stall is low; the register file update and the channel view are one pass of
// logic ahead of the result register, and a two-entry output (result register plus
// skid register) keeps req_ open while one result waits.
// Reset (synchronous, active high): register file cleared, pointer zero, device
// asleep, no transaction open, output empty.
//
// Register file and result path of the LED driver receiver.
// Depends on fcld_pkg.
module five_channel_led_driver_registers_unit #(
   parameter int NUM_CHANNELS = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  fcld_pkg::req_payload_type   req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output fcld_pkg::rsp_payload_type   rsp_payload
);

   localparam int ACTIVE = (NUM_CHANNELS < fcld_pkg::LAYOUT_CHANNELS) ?
                           NUM_CHANNELS : fcld_pkg::LAYOUT_CHANNELS;
   localparam logic [4:0] EN_MASK = 5'((1 << ACTIVE) - 1);
   localparam int LANES = fcld_pkg::LAYOUT_CHANNELS;

   // Device state
   logic [4:0] en_ff, en_in;
   logic [7:0] curr_ff [LANES];
   logic [7:0] curr_in [LANES];
   logic [4:0] lo_ff   [LANES];
   logic [4:0] lo_in   [LANES];
   logic [4:0] hi_ff   [LANES];
   logic [4:0] hi_in   [LANES];
   logic [4:0] wp_ff, wp_in;
   logic       sleep_ff, sleep_in;
   logic       open_ff, open_in;

   // Output stage
   logic                      rsp_valid_ff, rsp_valid_in;
   fcld_pkg::rsp_payload_type rsp_ff, rsp_in;
   logic                      skid_valid_ff, skid_valid_in;
   fcld_pkg::rsp_payload_type skid_ff, skid_in;

   logic                       accept;
   logic                       out_free;
   logic                       do_write;
   logic [3:0]                 wp4;
   logic [2:0]                 ch_raw;
   logic                       ch_ok;
   fcld_pkg::status_type       status_c;
   logic [4:0]                 reg_c;
   logic [7:0]                 sel_curr;
   logic [4:0]                 sel_lo;
   logic [4:0]                 sel_hi;
   logic                       sel_en;
   fcld_pkg::rsp_payload_type  rsp_c;

   assign req_stall   = skid_valid_ff;
   assign accept      = req_valid && !skid_valid_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign wp4         = wp_ff[3:0];

   // Byte decode: control state and write strobe
   always_comb begin
      sleep_in = sleep_ff;
      wp_in    = wp_ff;
      open_in  = open_ff;
      status_c = fcld_pkg::ST_OK;
      reg_c    = fcld_pkg::NO_REG;
      do_write = 1'b0;
      case (req_payload.op)
         fcld_pkg::OP_ADDR: begin
            if (!req_payload.data[fcld_pkg::ADDR_FLAG_BIT]) begin
               status_c = fcld_pkg::ST_ADDR_ERR;
               open_in  = 1'b0;
            end else begin
               sleep_in = !req_payload.data[fcld_pkg::AWAKE_BIT];
               wp_in    = {1'b0, req_payload.data[3:0]};
               open_in  = 1'b1;
            end
         end
         fcld_pkg::OP_DATA: begin
            if (!open_ff) begin
               status_c = fcld_pkg::ST_NO_TXN;
            end else if (wp_ff[4]) begin
               // pointer already past the last register: drop the byte
               status_c = fcld_pkg::ST_OVERFLOW;
               wp_in    = fcld_pkg::REG_COUNT;
            end else begin
               do_write = 1'b1;
               reg_c    = wp_ff;
               wp_in    = wp_ff + 5'd1;
            end
         end
         fcld_pkg::OP_STOP: begin
            open_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // Channel owning the addressed register
   always_comb begin
      if (wp4 >= fcld_pkg::GRAY_BASE) begin
         ch_raw = 3'((wp4 - fcld_pkg::GRAY_BASE) >> 1);
      end else begin
         ch_raw = 3'(wp4 - fcld_pkg::CURR_BASE);
      end
      ch_ok = do_write && (wp4 != fcld_pkg::REG_ENABLE) && (ch_raw < 3'(ACTIVE));
   end

   // Register file next values, one lane per channel
   always_comb begin
      en_in = en_ff;
      if (do_write && wp4 == fcld_pkg::REG_ENABLE) begin
         en_in = req_payload.data[4:0] & EN_MASK;
      end
      for (int k = 0; k < LANES; k++) begin
         curr_in[k] = curr_ff[k];
         lo_in[k]   = lo_ff[k];
         hi_in[k]   = hi_ff[k];
         if (do_write && wp4 == fcld_pkg::CURR_BASE + 4'(k)) begin
            curr_in[k] = req_payload.data;
         end
         if (do_write && wp4 == fcld_pkg::GRAY_BASE + 4'(2 * k)) begin
            lo_in[k] = req_payload.data[4:0];
         end
         if (do_write && wp4 == fcld_pkg::GRAY_BASE + 4'(2 * k + 1)) begin
            hi_in[k] = req_payload.data[4:0];
         end
      end
   end

   // Channel view after the write
   always_comb begin
      sel_curr = '0;
      sel_lo   = '0;
      sel_hi   = '0;
      sel_en   = 1'b0;
      for (int k = 0; k < LANES; k++) begin
         if (ch_raw == 3'(k)) begin
            sel_curr = curr_in[k];
            sel_lo   = lo_in[k];
            sel_hi   = hi_in[k];
            sel_en   = en_in[k];
         end
      end
      rsp_c.status       = status_c;
      rsp_c.asleep       = sleep_in;
      rsp_c.enable_mask  = en_in;
      rsp_c.reg_written  = reg_c;
      rsp_c.channel      = ch_ok ? ch_raw : fcld_pkg::NO_CHANNEL;
      rsp_c.current_code = ch_ok ? sel_curr : 8'd0;
      rsp_c.brightness   = (ch_ok && !sleep_in && sel_en) ? {sel_hi, sel_lo} : 10'd0;
   end

   // Output register and skid register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_in        = skid_ff;
            rsp_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            rsp_in       = rsp_c;
            rsp_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = rsp_c;
         skid_valid_in = 1'b1;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff    <= '0;
         wp_ff    <= '0;
         sleep_ff <= 1'b1;
         open_ff  <= 1'b0;
         for (int k = 0; k < LANES; k++) begin
            curr_ff[k] <= '0;
            lo_ff[k]   <= '0;
            hi_ff[k]   <= '0;
         end
      end else if (accept) begin
         en_ff    <= en_in;
         wp_ff    <= wp_in;
         sleep_ff <= sleep_in;
         open_ff  <= open_in;
         for (int k = 0; k < LANES; k++) begin
            curr_ff[k] <= curr_in[k];
            lo_ff[k]   <= lo_in[k];
            hi_ff[k]   <= hi_in[k];
         end
      end
   end

   // Output control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

`ifndef ASSERT_OFF
   // skid only fills behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register holds a result with the output register empty");

   // pointer never runs past one beyond the last register
   a_wp_range: assert property (@(posedge clock) disable iff (reset)
      wp_ff <= fcld_pkg::REG_COUNT)
      else $error("write pointer out of range");

   // a reported channel always comes from a successful register write
   a_channel_from_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.channel != fcld_pkg::NO_CHANNEL |->
         rsp_ff.status == fcld_pkg::ST_OK && rsp_ff.reg_written != fcld_pkg::NO_REG)
      else $error("channel reported without a register write");

   // lit output needs the device awake
   a_dark_when_asleep: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.asleep |-> rsp_ff.brightness == 10'd0)
      else $error("nonzero brightness while asleep");

   // a transfer into an empty output is offered on the next cycle
   a_accept_to_out: assert property (@(posedge clock) disable iff (reset)
      accept && !rsp_valid_ff |=> rsp_valid_ff)
      else $error("accepted byte produced no result");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for five_channel_led_driver_registers_unit: bus byte transfers
// in, per-byte status and channel view out. Depends on fcld_pkg and the unit RTL.
module tb;

   localparam int CH_COUNT     = 5;     // NUM_CHANNELS of the instance
   localparam int STALL_LIMIT  = 3000;  // cycles without any transfer
   localparam int HOLD_CYCLES  = 40;    // long receiver hold-off
   localparam int PHASE_BYTES  = 300;

   // Register-file shadow that predicts the view each byte reports
   class led_view_board;
      logic [7:0]                regs [16];
      logic [4:0]                ptr;
      logic                      asleep;
      logic                      txn_open;
      fcld_pkg::rsp_payload_type pending_views[$];
      int unsigned               mismatches;

      function new();
         foreach (regs[i]) regs[i] = 8'h00;
         ptr        = 5'd0;
         asleep     = 1'b1;
         txn_open   = 1'b0;
         mismatches = 0;
      endfunction

      function int pending();
         return pending_views.size();
      endfunction

      // Apply one accepted byte and queue the view it should produce
      function void note_byte(fcld_pkg::req_payload_type b);
         fcld_pkg::rsp_payload_type v;
         int                        active;
         int                        ch;
         int                        r;
         logic [4:0]                en;
         active = (CH_COUNT < fcld_pkg::LAYOUT_CHANNELS) ? CH_COUNT :
                  fcld_pkg::LAYOUT_CHANNELS;
         ch = int'(fcld_pkg::NO_CHANNEL);
         v = '0;
         v.status      = fcld_pkg::ST_OK;
         v.reg_written = fcld_pkg::NO_REG;
         case (b.op)
            fcld_pkg::OP_ADDR: begin
               if (!b.data[fcld_pkg::ADDR_FLAG_BIT]) begin
                  v.status = fcld_pkg::ST_ADDR_ERR;
                  txn_open = 1'b0;
               end else begin
                  // only bit 5 of the mode decoded
                  asleep   = !b.data[fcld_pkg::AWAKE_BIT];
                  ptr      = {1'b0, b.data[3:0]};
                  txn_open = 1'b1;
               end
            end
            fcld_pkg::OP_DATA: begin
               if (!txn_open) begin
                  v.status = fcld_pkg::ST_NO_TXN;
               end else if (ptr >= fcld_pkg::REG_COUNT) begin
                  v.status = fcld_pkg::ST_OVERFLOW;
                  ptr      = fcld_pkg::REG_COUNT;
               end else begin
                  r = int'(ptr[3:0]);
                  v.reg_written = ptr;
                  regs[r] = b.data;
                  ptr = ptr + 5'd1;
                  // owning channel of the written register
                  if (r >= int'(fcld_pkg::GRAY_BASE))
                     ch = (r - int'(fcld_pkg::GRAY_BASE)) >> 1;
                  else if (r >= int'(fcld_pkg::CURR_BASE))
                     ch = r - int'(fcld_pkg::CURR_BASE);
                  if (ch >= active) ch = int'(fcld_pkg::NO_CHANNEL);
               end
            end
            fcld_pkg::OP_STOP: txn_open = 1'b0;
            default: ;
         endcase
         en = regs[fcld_pkg::REG_ENABLE][4:0] & 5'((1 << active) - 1);
         v.asleep      = asleep;
         v.enable_mask = en;
         v.channel     = 3'(ch);
         if (ch != int'(fcld_pkg::NO_CHANNEL)) begin
            v.current_code = regs[int'(fcld_pkg::CURR_BASE) + ch];
            if (!asleep && en[ch])
               v.brightness = {regs[int'(fcld_pkg::GRAY_BASE) + 2 * ch + 1][4:0],
                               regs[int'(fcld_pkg::GRAY_BASE) + 2 * ch][4:0]};
         end
         pending_views.push_back(v);
      endfunction

      // Compare one result transfer with the oldest predicted view
      function void check_view(fcld_pkg::rsp_payload_type got);
         fcld_pkg::rsp_payload_type exp_v;
         if (pending_views.size() == 0) begin
            $error("result transfer with no byte outstanding: %h", got);
            mismatches++;
            return;
         end
         exp_v = pending_views.pop_front();
         if (got.status !== exp_v.status) begin
            $error("status: expected %0d, actual %0d", exp_v.status, got.status);
            mismatches++;
         end
         if (got.asleep !== exp_v.asleep) begin
            $error("asleep: expected %0d, actual %0d", exp_v.asleep, got.asleep);
            mismatches++;
         end
         if (got.enable_mask !== exp_v.enable_mask) begin
            $error("enable_mask: expected %h, actual %h", exp_v.enable_mask, got.enable_mask);
            mismatches++;
         end
         if (got.reg_written !== exp_v.reg_written) begin
            $error("reg_written: expected %0d, actual %0d", exp_v.reg_written,
                   got.reg_written);
            mismatches++;
         end
         if (got.channel !== exp_v.channel) begin
            $error("channel: expected %0d, actual %0d", exp_v.channel, got.channel);
            mismatches++;
         end
         if (got.brightness !== exp_v.brightness) begin
            $error("brightness: expected %0d, actual %0d", exp_v.brightness, got.brightness);
            mismatches++;
         end
         if (got.current_code !== exp_v.current_code) begin
            $error("current_code: expected %h, actual %h", exp_v.current_code,
                   got.current_code);
            mismatches++;
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   fcld_pkg::req_payload_type req_payload;
   logic                      rsp_valid;
   logic                      rsp_stall;
   fcld_pkg::rsp_payload_type rsp_payload;

   led_view_board board;
   int            bytes_sent;
   int            send_idle_pct;
   int            rsp_stall_pct;
   logic          hold_request;
   int            hold_left;
   int            quiet_cycles;

   five_channel_led_driver_registers_unit #(.NUM_CHANNELS(CH_COUNT)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver: random stall, or a long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request <= 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_view(rsp_payload);
   end

   // Watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // One byte transfer on req_, with random idle cycles ahead of it
   task automatic send_byte(input fcld_pkg::op_type op, input logic [7:0] value);
      fcld_pkg::req_payload_type b;
      b.op   = op;
      b.data = value;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= b;
      do @(posedge clock); while (req_stall);
      board.note_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Stop offering bytes until every predicted view has arrived
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (board.pending() != 0);
   endtask

   // Mostly well-formed write transactions, some noise and broken sequences
   task automatic send_transaction();
      int         kind;
      int         n;
      logic [3:0] start;
      logic [7:0] a;
      kind = $urandom_range(99);
      if (kind < 80) begin
         start = ($urandom_range(3) == 0) ? 4'd0 : 4'($urandom_range(15));
         a = {1'b1, 1'($urandom_range(1)), ($urandom_range(3) != 0),
              1'($urandom_range(1)), start};
         send_byte(fcld_pkg::OP_ADDR, a);
         n = ($urandom_range(7) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
         repeat (n) send_byte(fcld_pkg::OP_DATA, 8'($urandom));
         if ($urandom_range(9) != 0) send_byte(fcld_pkg::OP_STOP, 8'($urandom));
      end else begin
         repeat ($urandom_range(1, 3))
            send_byte(fcld_pkg::op_type'($urandom_range(3)), 8'($urandom));
      end
   endtask

   // One idling setting; a long receiver hold-off and a full drain midway
   task automatic run_phase(input int idle_in, input int stall_out);
      int first;
      bit held;
      bit drained;
      first   = bytes_sent;
      held    = 1'b0;
      drained = 1'b0;
      send_idle_pct = idle_in;
      rsp_stall_pct <= stall_out;
      while (bytes_sent - first < PHASE_BYTES) begin
         send_transaction();
         if (!held && bytes_sent - first > PHASE_BYTES / 3) begin
            hold_request <= 1'b1;
            held = 1'b1;
         end
         if (!drained && bytes_sent - first > 2 * PHASE_BYTES / 3) begin
            wait_drained();
            drained = 1'b1;
         end
      end
   endtask

   initial begin
      board         = new();
      bytes_sent    = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_request  = 1'b0;
      quiet_cycles  = 0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_payload   = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: errors, register map edges, mode decode, overflow
      send_byte(fcld_pkg::OP_DATA, 8'hFF);      // data before any address
      send_byte(fcld_pkg::OP_ADDR, 8'h00);      // address lacking the flag bit
      send_byte(fcld_pkg::OP_ADDR, 8'h80);      // sleep, start at enables
      send_byte(fcld_pkg::OP_DATA, 8'h1F);
      send_byte(fcld_pkg::OP_DATA, 8'hFF);      // channel 0 current while asleep
      send_byte(fcld_pkg::OP_STOP, 8'h00);
      send_byte(fcld_pkg::OP_ADDR, 8'hA6);      // awake, channel 0 brightness
      send_byte(fcld_pkg::OP_DATA, 8'hFF);
      send_byte(fcld_pkg::OP_DATA, 8'hFF);
      send_byte(fcld_pkg::OP_DATA, 8'h00);
      send_byte(fcld_pkg::OP_DATA, 8'h00);
      send_byte(fcld_pkg::OP_ADDR, 8'hBF);      // mode 11 decodes as awake, last register
      send_byte(fcld_pkg::OP_DATA, 8'h55);
      send_byte(fcld_pkg::OP_DATA, 8'hAA);      // past the end of the file
      send_byte(fcld_pkg::OP_DATA, 8'h01);
      send_byte(fcld_pkg::OP_STOP, 8'hFF);
      send_byte(fcld_pkg::OP_UNUSED, 8'hFF);
      send_byte(fcld_pkg::OP_DATA, 8'h33);      // after stop
      send_byte(fcld_pkg::OP_ADDR, 8'h90);      // mode 01 decodes as sleep
      send_byte(fcld_pkg::OP_DATA, 8'h00);
      send_byte(fcld_pkg::OP_STOP, 8'h00);
      send_byte(fcld_pkg::OP_ADDR, 8'hE0);
      send_byte(fcld_pkg::OP_DATA, 8'hEA);      // partial enables, upper bits ignored
      send_byte(fcld_pkg::OP_UNUSED, 8'h00);
      send_byte(fcld_pkg::OP_STOP, 8'h00);

      run_phase(24, 58);
      run_phase(58, 24);
      run_phase(0, 0);

      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
